@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge, disabled while reset is asserted.
`define CBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/cbs_pkg.sv @@
// ---------------------------------------------------------------------------
// cbs_pkg
// Constants, codes and control types of the cuckoo bucket store.
// ---------------------------------------------------------------------------
package cbs_pkg;

  localparam int LOCAL_BUCKETS    = 64;
  localparam int REPLAY_DEPTH     = 16;
  localparam int SLOTS_PER_BUCKET = 4;

  localparam int LB_W   = (LOCAL_BUCKETS > 1) ? $clog2(LOCAL_BUCKETS) : 1;
  localparam int RD_W   = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
  localparam int SL_W   = $clog2(SLOTS_PER_BUCKET);
  localparam int TAG_W  = 8;
  localparam int ROW_W  = SLOTS_PER_BUCKET * TAG_W;
  localparam int BKT_W  = 16;
  localparam int SRC_W  = 16;
  localparam int SEQ_W  = 8;
  localparam int OP_W   = 32;
  localparam int TYPE_W = 3;
  localparam int ST_W   = 2;
  localparam int LFSR_W = 16;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RESET  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_PING   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_KICKED    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RST  = 16'd44257;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd_row;
    logic exec;
    logic replay;
    logic plain;
  } cbs_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              cache_hit;
    logic              scan_done;
  } cbs_stat_t;

endpackage

@@ hdl/cbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// cbs_ctrl
// Request sequencer: cache check, map scan, bucket read and update.
// ---------------------------------------------------------------------------
module cbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cbs_pkg::cbs_stat_t stat_i,
  output cbs_pkg::cbs_cmd_t  cmd_o,
  output logic              busy_o
);
  import cbs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CACHE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CACHE;
        end
      end
      S_CACHE: begin
        case (stat_i.req_type)
          REQ_INSERT, REQ_DELETE: begin
            if (stat_i.cache_hit) begin
              cmd_o.replay = 1'b1;
              state_d      = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end
          REQ_LOOKUP: state_d = S_SCAN;
          REQ_RESET, REQ_PING: begin
            cmd_o.plain = 1'b1;
            state_d     = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_row = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ hdl/cbs_datapath.sv @@
// ---------------------------------------------------------------------------
// cbs_datapath
// Bucket map, tag rows, replay cache, eviction LFSR and result register.
// ---------------------------------------------------------------------------
module cbs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cbs_pkg::cbs_cmd_t           cmd_i,
  output cbs_pkg::cbs_stat_t          stat_o,
  input  logic                        cfg_we_i,
  input  logic [cbs_pkg::LFSR_W-1:0]  cfg_data_i,
  input  logic [cbs_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [cbs_pkg::SRC_W-1:0]   src_id_i,
  input  logic [cbs_pkg::SEQ_W-1:0]   seq_i,
  input  logic [cbs_pkg::OP_W-1:0]    op_id_i,
  input  logic [cbs_pkg::BKT_W-1:0]   bucket_i,
  input  logic [cbs_pkg::TAG_W-1:0]   fingerprint_i,
  input  logic                        no_evict_i,
  output logic                        done_o,
  output logic [cbs_pkg::ST_W-1:0]    status_o,
  output logic [cbs_pkg::TAG_W-1:0]   kicked_fp_o,
  output logic [cbs_pkg::SEQ_W-1:0]   ack_seq_o,
  output logic                        chain_reply_o
);
  import cbs_pkg::*;

  // Latched request.
  logic [TYPE_W-1:0] type_q;
  logic [SRC_W-1:0]  src_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [OP_W-1:0]   op_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [TAG_W-1:0]  fp_q;
  logic              try_q;

  // Map and tag storage.
  logic [LOCAL_BUCKETS-1:0] map_vld_q;
  logic [BKT_W-1:0]         map_mem [LOCAL_BUCKETS];
  logic [ROW_W-1:0]         tag_mem [LOCAL_BUCKETS];
  logic [BKT_W-1:0]         map_rd_q;
  logic [ROW_W-1:0]         row_q;

  // Scan pipeline.
  logic [LB_W:0]   cnt_q;
  logic            pvld_q;
  logic [LB_W-1:0] pidx_q;
  logic            found_q, free_found_q;
  logic [LB_W-1:0] found_idx_q, free_idx_q;
  logic            match;

  // Replay cache.
  logic [REPLAY_DEPTH-1:0] c_vld_q;
  logic [SRC_W-1:0]        c_src_q [REPLAY_DEPTH];
  logic [SEQ_W-1:0]        c_seq_q [REPLAY_DEPTH];
  logic [OP_W-1:0]         c_op_q  [REPLAY_DEPTH];
  logic [ST_W-1:0]         c_st_q  [REPLAY_DEPTH];
  logic [TAG_W-1:0]        c_ev_q  [REPLAY_DEPTH];
  logic [RD_W-1:0]         wptr_q;
  logic                    hit;
  logic [RD_W-1:0]         hit_idx;
  logic [OP_W-1:0]         key_op;

  logic [LFSR_W-1:0] seed_q, lfsr_q, lfsr_next;

  // Update logic.
  logic              is_ins, is_del;
  logic              vac_any, fm_any, left_any;
  logic [SL_W-1:0]   vac_slot, fm_slot, kick_slot;
  logic [ROW_W-1:0]  row_new;
  logic              tag_we, map_we, vld_clr, rec, lfsr_step;
  logic [LB_W-1:0]   tag_waddr;
  logic [ST_W-1:0]   ex_st;
  logic [TAG_W-1:0]  ex_ev;

  assign is_ins = (type_q == REQ_INSERT);
  assign is_del = (type_q == REQ_DELETE);
  assign key_op = is_ins ? op_q : '0;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = REPLAY_DEPTH - 1; i >= 0; i--) begin
      if (c_vld_q[i] && c_src_q[i] == src_q && c_seq_q[i] == seq_q && c_op_q[i] == key_op)
      begin
        hit     = 1'b1;
        hit_idx = RD_W'(i);
      end
    end
  end

  assign match = pvld_q && map_vld_q[pidx_q] && (map_rd_q == bkt_q);

  assign stat_o.req_type  = type_q;
  assign stat_o.cache_hit = hit;
  assign stat_o.scan_done = pvld_q && (match || pidx_q == LB_W'(LOCAL_BUCKETS - 1));

  assign lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);
  assign kick_slot = SL_W'(lfsr_q % SLOTS_PER_BUCKET);

  always_comb begin
    vac_any  = 1'b0;
    vac_slot = '0;
    fm_any   = 1'b0;
    fm_slot  = '0;
    for (int k = SLOTS_PER_BUCKET - 1; k >= 0; k--) begin
      if (row_q[k*TAG_W +: TAG_W] == '0) begin
        vac_any  = 1'b1;
        vac_slot = SL_W'(k);
      end
      if (row_q[k*TAG_W +: TAG_W] == fp_q) begin
        fm_any  = 1'b1;
        fm_slot = SL_W'(k);
      end
    end
  end

  always_comb begin
    row_new   = row_q;
    tag_we    = 1'b0;
    map_we    = 1'b0;
    vld_clr   = 1'b0;
    rec       = 1'b0;
    lfsr_step = 1'b0;
    tag_waddr = found_idx_q;
    ex_st     = ST_NOT_FOUND;
    ex_ev     = '0;
    left_any  = 1'b0;
    case (type_q)
      REQ_INSERT: begin
        rec   = 1'b1;
        ex_st = ST_OK;
        if (fp_q == '0) begin
          ex_st = ST_OK;
        end else if (found_q) begin
          if (vac_any) begin
            row_new[vac_slot*TAG_W +: TAG_W] = fp_q;
            tag_we = 1'b1;
          end else if (try_q) begin
            ex_st = ST_FULL;
          end else begin
            ex_ev = row_q[kick_slot*TAG_W +: TAG_W];
            row_new[kick_slot*TAG_W +: TAG_W] = fp_q;
            tag_we    = 1'b1;
            ex_st     = ST_KICKED;
            lfsr_step = 1'b1;
          end
        end else if (free_found_q) begin
          // New mapping starts with an empty row holding only this tag.
          row_new              = '0;
          row_new[TAG_W-1:0]   = fp_q;
          tag_we               = 1'b1;
          tag_waddr            = free_idx_q;
          map_we               = 1'b1;
        end else begin
          ex_st = ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (found_q && fp_q != '0 && fm_any) begin
          ex_st = ST_OK;
        end
      end
      REQ_DELETE: begin
        rec = 1'b1;
        if (found_q && fp_q != '0 && fm_any) begin
          row_new[fm_slot*TAG_W +: TAG_W] = '0;
          tag_we   = 1'b1;
          ex_st    = ST_OK;
          left_any = |row_new;
          vld_clr  = !left_any;
        end
      end
      default: ex_st = ST_OK;
    endcase
  end

  // Storage arrays, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      map_rd_q <= map_mem[cnt_q[LB_W-1:0]];
    end
    if (cmd_i.rd_row) begin
      row_q <= tag_mem[found_idx_q];
    end
    if (cmd_i.exec && map_we) begin
      map_mem[free_idx_q] <= bkt_q;
    end
    if (cmd_i.exec && tag_we) begin
      tag_mem[tag_waddr] <= row_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      src_q  <= src_id_i;
      seq_q  <= seq_i;
      op_q   <= op_id_i;
      bkt_q  <= bucket_i;
      fp_q   <= fingerprint_i;
      try_q  <= no_evict_i;
    end
    if (cmd_i.exec && rec) begin
      c_src_q[wptr_q] <= src_q;
      c_seq_q[wptr_q] <= seq_q;
      c_op_q[wptr_q]  <= key_op;
      c_st_q[wptr_q]  <= ex_st;
      c_ev_q[wptr_q]  <= ex_ev;
    end
    if (cmd_i.load) begin
      found_idx_q <= '0;
      free_idx_q  <= '0;
    end else if (pvld_q) begin
      if (match) begin
        found_idx_q <= pidx_q;
      end
      if (!map_vld_q[pidx_q] && !free_found_q) begin
        free_idx_q <= pidx_q;
      end
    end
    if (cmd_i.scan) begin
      pidx_q <= cnt_q[LB_W-1:0];
    end
    if (cmd_i.exec || cmd_i.replay || cmd_i.plain) begin
      ack_seq_o <= seq_q;
      chain_reply_o <= is_ins;
      if (cmd_i.exec) begin
        status_o    <= ex_st;
        kicked_fp_o <= ex_ev;
      end else if (cmd_i.replay) begin
        status_o    <= c_st_q[hit_idx];
        kicked_fp_o <= is_ins ? c_ev_q[hit_idx] : '0;
      end else begin
        status_o    <= ST_OK;
        kicked_fp_o <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pvld_q       <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      map_vld_q    <= '0;
      c_vld_q      <= '0;
      wptr_q       <= '0;
      seed_q       <= SEED_RST;
      lfsr_q       <= SEED_RST;
      done_o       <= 1'b0;
    end else begin
      done_o <= cmd_i.exec || cmd_i.replay || cmd_i.plain;
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        cnt_q        <= '0;
        pvld_q       <= 1'b0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        pvld_q <= cmd_i.scan && !cnt_q[LB_W] && !stat_o.scan_done;
        if (cmd_i.scan && !cnt_q[LB_W]) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (match) begin
          found_q <= 1'b1;
        end
        if (pvld_q && !map_vld_q[pidx_q]) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.exec) begin
        if (map_we) begin
          map_vld_q[free_idx_q] <= 1'b1;
        end
        if (vld_clr) begin
          map_vld_q[found_idx_q] <= 1'b0;
        end
        if (rec) begin
          c_vld_q[wptr_q] <= 1'b1;
          wptr_q <= (wptr_q == RD_W'(REPLAY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
        end
        if (lfsr_step) begin
          lfsr_q <= lfsr_next;
        end
      end
      if (cmd_i.plain && type_q == REQ_RESET) begin
        map_vld_q <= '0;
        c_vld_q   <= '0;
        wptr_q    <= '0;
        lfsr_q    <= (seed_q == '0) ? LFSR_W'(1) : seed_q;
      end
    end
  end

endmodule

@@ hdl/cuckoo_bucket_store_with_replay_cache.sv @@
// ---------------------------------------------------------------------------
// cuckoo_bucket_store_with_replay_cache
// Ping, reset and replays strobe after the cache check; others after a scan
// of the map to the matching entry (all of it if unmapped, one entry a cycle),
// a row read and an update. busy falls with the strobe; one request at a time.
// Asynchronous reset empties the map and replay cache and reloads the seed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cuckoo_bucket_store_with_replay_cache (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [cbs_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [cbs_pkg::SRC_W-1:0]   src_id_i,
  input  logic [cbs_pkg::SEQ_W-1:0]   seq_i,
  input  logic [cbs_pkg::OP_W-1:0]    op_id_i,
  input  logic [cbs_pkg::BKT_W-1:0]   bucket_i,
  input  logic [cbs_pkg::TAG_W-1:0]   fingerprint_i,
  input  logic                        no_evict_i,
  output logic                        done_o,
  output logic [cbs_pkg::ST_W-1:0]    status_o,
  output logic [cbs_pkg::TAG_W-1:0]   kicked_fp_o,
  output logic [cbs_pkg::SEQ_W-1:0]   ack_seq_o,
  output logic                        chain_reply_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cbs_pkg::LFSR_W-1:0]  cfg_data_i
);
  import cbs_pkg::*;

  cbs_cmd_t  cmd;
  cbs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  cbs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  cbs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .src_id_i      (src_id_i),
    .seq_i         (seq_i),
    .op_id_i       (op_id_i),
    .bucket_i      (bucket_i),
    .fingerprint_i (fingerprint_i),
    .no_evict_i    (no_evict_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .kicked_fp_o   (kicked_fp_o),
    .ack_seq_o     (ack_seq_o),
    .chain_reply_o (chain_reply_o)
  );

  `CBS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `CBS_ASSERT_NEVER(a_done_idle, done_o && busy, "result strobe while still busy")
  `CBS_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result strobe without a request")

endmodule

@@ sim/cuckoo_bucket_store_with_replay_cache_tb.sv @@
// ---------------------------------------------------------------------------
// cuckoo_bucket_store_with_replay_cache_tb
// Drives insert, lookup, delete, reset and ping requests into the bucket
// store and checks every reply against a cycle-free model of the map, the
// slots, the eviction LFSR and the replay cache. The LFSR seed is changed
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module cuckoo_bucket_store_with_replay_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbs_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} entry_kind_e;

  typedef struct {
    entry_kind_e       kind;
    logic [TYPE_W-1:0] rtype;
    logic [SRC_W-1:0]  src;
    logic [SEQ_W-1:0]  seq;
    logic [OP_W-1:0]   op;
    logic [BKT_W-1:0]  bkt;
    logic [TAG_W-1:0]  fp;
    logic              no_evict;
    logic              calm;
    logic [LFSR_W-1:0] seed;
  } entry_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [TAG_W-1:0] evicted;
    logic [SEQ_W-1:0] ack_seq;
    logic             chain;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TYPE_W-1:0] req_type_i = '0;
  logic [SRC_W-1:0] src_id_i = '0;
  logic [SEQ_W-1:0] seq_i = '0;
  logic [OP_W-1:0] op_id_i = '0;
  logic [BKT_W-1:0] bucket_i = '0;
  logic [TAG_W-1:0] fingerprint_i = '0;
  logic no_evict_i = 1'b0;
  logic done_o;
  logic [ST_W-1:0] status_o;
  logic [TAG_W-1:0] kicked_fp_o;
  logic [SEQ_W-1:0] ack_seq_o;
  logic chain_reply_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LFSR_W-1:0] cfg_data_i = '0;

  cuckoo_bucket_store_with_replay_cache DUT (.*);

  // Model state of the store.
  logic              map_vld [LOCAL_BUCKETS];
  logic [BKT_W-1:0]  map_bkt [LOCAL_BUCKETS];
  logic [TAG_W-1:0]  slot_tag [LOCAL_BUCKETS*SLOTS_PER_BUCKET];
  logic              rc_vld [REPLAY_DEPTH];
  logic [SRC_W-1:0]  rc_src [REPLAY_DEPTH];
  logic [SEQ_W-1:0]  rc_seq [REPLAY_DEPTH];
  logic [OP_W-1:0]   rc_op [REPLAY_DEPTH];
  logic [ST_W-1:0]   rc_st [REPLAY_DEPTH];
  logic [TAG_W-1:0]  rc_ev [REPLAY_DEPTH];
  int                rc_wp;
  logic [LFSR_W-1:0] evict_lfsr;
  logic [LFSR_W-1:0] seed_reg = SEED_RST;

  entry_t stim_q[$];
  entry_t retry_q[$];
  reply_t reply_q[$];
  entry_t cur;
  int gap = 0;
  int quiet = 0;
  int errors = 0;
  int cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic clear_store();
    for (int i = 0; i < LOCAL_BUCKETS; i++) map_vld[i] = 1'b0;
    for (int i = 0; i < LOCAL_BUCKETS*SLOTS_PER_BUCKET; i++) slot_tag[i] = '0;
    for (int i = 0; i < REPLAY_DEPTH; i++) rc_vld[i] = 1'b0;
    rc_wp = 0;
    evict_lfsr = (seed_reg == 0) ? LFSR_W'(1) : seed_reg;
  endtask

  function automatic int find_entry(input logic [BKT_W-1:0] b);
    for (int i = 0; i < LOCAL_BUCKETS; i++)
      if (map_vld[i] && map_bkt[i] == b) return i;
    return -1;
  endfunction

  task automatic record(input entry_t r, input logic [OP_W-1:0] op,
                        input logic [ST_W-1:0] st, input logic [TAG_W-1:0] ev);
    rc_vld[rc_wp] = 1'b1;
    rc_src[rc_wp] = r.src;
    rc_seq[rc_wp] = r.seq;
    rc_op[rc_wp]  = op;
    rc_st[rc_wp]  = st;
    rc_ev[rc_wp]  = ev;
    rc_wp = (rc_wp + 1) % REPLAY_DEPTH;
  endtask

  // Works out the reply of one accepted request and updates the store.
  task automatic predict_reply(input entry_t r);
    reply_t e;
    logic [OP_W-1:0] key_op;
    int hit, m, b;
    e = '{status: ST_OK, evicted: '0, ack_seq: r.seq, chain: 1'b0};
    if (r.rtype >= REQ_UNKNOWN_LO) return;
    hit = -1;
    key_op = (r.rtype == REQ_INSERT) ? r.op : '0;
    if (r.rtype == REQ_INSERT || r.rtype == REQ_DELETE)
      for (int i = 0; i < REPLAY_DEPTH; i++)
        if (hit < 0 && rc_vld[i] && rc_src[i] == r.src && rc_seq[i] == r.seq &&
            rc_op[i] == key_op) hit = i;
    m = find_entry(r.bkt);
    case (r.rtype)
      REQ_INSERT: begin
        e.chain = 1'b1;
        if (hit >= 0) begin
          e.status = rc_st[hit];
          e.evicted = rc_ev[hit];
        end else begin
          if (r.fp != 0) begin
            if (m < 0) begin
              for (int i = 0; i < LOCAL_BUCKETS; i++)
                if (m < 0 && !map_vld[i]) m = i;
              if (m >= 0) begin
                map_vld[m] = 1'b1;
                map_bkt[m] = r.bkt;
                for (int k = 0; k < SLOTS_PER_BUCKET; k++)
                  slot_tag[m*SLOTS_PER_BUCKET+k] = '0;
              end
            end
            if (m < 0) begin
              e.status = ST_FULL;
            end else begin
              b = -1;
              for (int k = 0; k < SLOTS_PER_BUCKET; k++)
                if (b < 0 && slot_tag[m*SLOTS_PER_BUCKET+k] == 0) b = k;
              if (b >= 0) begin
                slot_tag[m*SLOTS_PER_BUCKET+b] = r.fp;
              end else if (r.no_evict) begin
                e.status = ST_FULL;
              end else begin
                b = evict_lfsr % SLOTS_PER_BUCKET;
                e.evicted = slot_tag[m*SLOTS_PER_BUCKET+b];
                slot_tag[m*SLOTS_PER_BUCKET+b] = r.fp;
                e.status = ST_KICKED;
                evict_lfsr = (evict_lfsr >> 1) ^ (evict_lfsr[0] ? LFSR_MASK : '0);
              end
            end
          end
          record(r, key_op, e.status, e.evicted);
        end
      end
      REQ_LOOKUP: begin
        e.status = ST_NOT_FOUND;
        if (m >= 0 && r.fp != 0)
          for (int k = 0; k < SLOTS_PER_BUCKET; k++)
            if (slot_tag[m*SLOTS_PER_BUCKET+k] == r.fp) e.status = ST_OK;
      end
      REQ_DELETE: begin
        if (hit >= 0) begin
          e.status = rc_st[hit];
        end else begin
          e.status = ST_NOT_FOUND;
          b = -1;
          if (m >= 0 && r.fp != 0)
            for (int k = 0; k < SLOTS_PER_BUCKET; k++)
              if (b < 0 && slot_tag[m*SLOTS_PER_BUCKET+k] == r.fp) b = k;
          if (b >= 0) begin
            slot_tag[m*SLOTS_PER_BUCKET+b] = '0;
            e.status = ST_OK;
            map_vld[m] = 1'b0;
            for (int k = 0; k < SLOTS_PER_BUCKET; k++)
              if (slot_tag[m*SLOTS_PER_BUCKET+k] != 0) map_vld[m] = 1'b1;
          end
          record(r, key_op, e.status, '0);
        end
      end
      REQ_RESET: clear_store();
      default: ;
    endcase
    reply_q.push_back(e);
  endtask

  task automatic add_req(input logic [TYPE_W-1:0] t, input logic [SRC_W-1:0] s,
                         input logic [SEQ_W-1:0] q, input logic [OP_W-1:0] op,
                         input logic [BKT_W-1:0] b, input logic [TAG_W-1:0] fp,
                         input logic tr, input logic calm);
    entry_t e;
    e = '{kind: K_REQ, rtype: t, src: s, seq: q, op: op, bkt: b, fp: fp,
          no_evict: tr, calm: calm, seed: '0};
    stim_q.push_back(e);
    if (t == REQ_INSERT || t == REQ_DELETE) begin
      retry_q.push_back(e);
      if (retry_q.size() > 8) void'(retry_q.pop_front());
    end
  endtask

  task automatic add_marker(input entry_kind_e k, input logic [LFSR_W-1:0] sd);
    entry_t e;
    e = '{kind: k, rtype: REQ_PING, src: '0, seq: '0, op: '0, bkt: '0, fp: '0,
          no_evict: 1'b0, calm: 1'b0, seed: sd};
    stim_q.push_back(e);
  endtask

  // Random requests over a small pool of buckets and tags, so that buckets
  // fill up, evictions happen and deletes find their tags.
  task automatic add_random(input int n, input int span, input bit resets,
                            input logic calm);
    entry_t e;
    int p, t;
    logic [TYPE_W-1:0] rt;
    logic [SRC_W-1:0] s;
    logic [OP_W-1:0] op;
    logic [BKT_W-1:0] b;
    logic [TAG_W-1:0] fp;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 12 && retry_q.size() > 0) begin
        e = retry_q[$urandom_range(0, retry_q.size() - 1)];
        e.calm = calm;
        stim_q.push_back(e);
        continue;
      end
      t = $urandom_range(0, 99);
      if (t < 42) rt = REQ_INSERT;
      else if (t < 60) rt = REQ_LOOKUP;
      else if (t < 85) rt = REQ_DELETE;
      else if (t < 87 && resets) rt = REQ_RESET;
      else if (t < 94) rt = REQ_PING;
      else if (t < 97) rt = REQ_UNKNOWN_LO + TYPE_W'($urandom_range(0, 2));
      else rt = REQ_INSERT;
      s = ($urandom_range(0, 9) < 7) ? SRC_W'($urandom_range(0, 3)) : SRC_W'($urandom);
      p = $urandom_range(0, 9);
      op = (p < 4) ? '0 : (p < 7) ? OP_W'($urandom_range(1, 3)) : OP_W'($urandom);
      b = ($urandom_range(0, 9) == 0) ? BKT_W'($urandom) : BKT_W'($urandom_range(0, span - 1));
      fp = ($urandom_range(0, 9) < 8) ? TAG_W'($urandom_range(1, 10))
                                      : TAG_W'($urandom_range(0, 255));
      add_req(rt, s, SEQ_W'($urandom_range(0, 255)), op, b, fp, 1'(($urandom)), calm);
    end
  endtask

  // Driver: one beat at a time on the request port or the seed port.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_reply(cur);
        if (!cur.calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      end
      if (cfg_valid_i && cfg_ready_o) seed_reg = cfg_data_i;
      if (reply_q.size() == 0 && !busy && !start && !cfg_valid_i) quiet++;
      else quiet = 0;
      if ((start && busy) || (cfg_valid_i && !cfg_ready_o)) begin
        // Hold the current beat until it is taken.
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (stim_q.size() != 0 && stim_q[0].kind == K_REQ) begin
        cur = stim_q.pop_front();
        req_type_i <= cur.rtype;
        src_id_i <= cur.src;
        seq_i <= cur.seq;
        op_id_i <= cur.op;
        bucket_i <= cur.bkt;
        fingerprint_i <= cur.fp;
        no_evict_i <= cur.no_evict;
        start <= 1'b1;
        cfg_valid_i <= 1'b0;
      end else if (stim_q.size() != 0 && quiet >= HOLD_CYCLES) begin
        if (stim_q[0].kind == K_CFG) begin
          cfg_data_i <= stim_q[0].seed;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
        void'(stim_q.pop_front());
        start <= 1'b0;
      end else begin
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobed reply must match the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        flag_error($sformatf("unexpected reply ack_seq=%0d", ack_seq_o));
      end else begin
        reply_t e;
        e = reply_q.pop_front();
        if (status_o !== e.status)
          flag_error($sformatf("status %0d, want %0d", status_o, e.status));
        if (kicked_fp_o !== e.evicted)
          flag_error($sformatf("kicked_fp %0d, want %0d", kicked_fp_o, e.evicted));
        if (ack_seq_o !== e.ack_seq)
          flag_error($sformatf("ack_seq %0d, want %0d", ack_seq_o, e.ack_seq));
        if (chain_reply_o !== e.chain)
          flag_error($sformatf("chain_reply %0d, want %0d", chain_reply_o, e.chain));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cuckoo_bucket_store_with_replay_cache_tb: done, errors");
      $finish;
    end
  end

  initial begin
    clear_store();
    // Directed part.
    add_marker(K_CFG, 16'd1);
    add_req(REQ_PING, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
    add_req(REQ_RESET, 16'd0, 8'd1, 32'd0, 16'd0, 8'd1, 1'b0, 1'b0);
    add_req(REQ_INSERT, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
    add_req(REQ_LOOKUP, 16'd0, 8'd2, 32'd0, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
    add_req(REQ_LOOKUP, 16'd0, 8'd3, 32'd0, 16'hFFFF, 8'd0, 1'b0, 1'b0);
    add_req(REQ_LOOKUP, 16'd0, 8'd4, 32'd0, 16'd77, 8'd5, 1'b0, 1'b0);
    add_req(REQ_INSERT, 16'd1, 8'd5, 32'd9, 16'd3, 8'd0, 1'b0, 1'b0);
    for (int k = 1; k <= 4; k++)
      add_req(REQ_INSERT, 16'd1, SEQ_W'(10 + k), 32'd1, 16'd0, TAG_W'(k), 1'b0, 1'b0);
    add_req(REQ_INSERT, 16'd1, 8'd20, 32'd1, 16'd0, 8'd9, 1'b1, 1'b0);
    add_req(REQ_INSERT, 16'd1, 8'd21, 32'd1, 16'd0, 8'd9, 1'b0, 1'b0);
    add_req(REQ_INSERT, 16'd1, 8'd21, 32'd1, 16'd0, 8'd9, 1'b0, 1'b0);
    add_req(REQ_DELETE, 16'd1, 8'd22, 32'd5, 16'd0, 8'd0, 1'b0, 1'b0);
    add_req(REQ_DELETE, 16'd1, 8'd23, 32'd5, 16'd99, 8'd2, 1'b0, 1'b0);
    add_req(REQ_DELETE, 16'd2, 8'd24, 32'd5, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
    add_req(REQ_DELETE, 16'd2, 8'd24, 32'd7, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
    // An insert with op_id 0 shares its key with the delete just above.
    add_req(REQ_INSERT, 16'd2, 8'd24, 32'd0, 16'd5, 8'd6, 1'b0, 1'b0);
    add_req(REQ_UNKNOWN_HI, 16'd0, 8'd25, 32'd0, 16'd0, 8'd1, 1'b0, 1'b0);
    add_req(REQ_LOOKUP, 16'd0, 8'd26, 32'd0, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
    add_req(REQ_PING, 16'h5A5A, 8'h00, 32'h0, 16'h0, 8'h1, 1'b0, 1'b0);
    add_marker(K_DRAIN, '0);
    // Random part over several seeds, with a phase that fills the map.
    add_random(130, 8, 1, 1'b0);
    add_marker(K_CFG, 16'hFFFF);
    add_req(REQ_RESET, 16'd0, 8'd0, 32'd0, 16'd0, 8'd1, 1'b0, 1'b0);
    add_random(200, 80, 0, 1'b0);
    add_marker(K_CFG, 16'd0);
    add_req(REQ_RESET, 16'd0, 8'd0, 32'd0, 16'd0, 8'd1, 1'b0, 1'b0);
    add_random(80, 8, 1, 1'b0);
    add_marker(K_CFG, LFSR_W'($urandom_range(1, 65535)));
    add_req(REQ_RESET, 16'd0, 8'd0, 32'd0, 16'd0, 8'd1, 1'b0, 1'b0);
    add_random(80, 8, 1, 1'b1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (stim_q.size() != 0 || start || cfg_valid_i || reply_q.size() != 0);
    repeat (HOLD_CYCLES) @(negedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("cuckoo_bucket_store_with_replay_cache_tb: done, clean");
    end else begin
      $display("cuckoo_bucket_store_with_replay_cache_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cbs_pkg.sv
hdl/cbs_ctrl.sv
hdl/cbs_datapath.sv
hdl/cuckoo_bucket_store_with_replay_cache.sv
sim/cuckoo_bucket_store_with_replay_cache_tb.sv
